[rtl/stable_time_ordered_event_queue_macros.svh]
// Assertion macros for the event queue RTL.
`ifndef STABLE_TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define STABLE_TIME_ORDERED_EVENT_QUEUE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define STOEQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define STOEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STOEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/stoeq_pkg.sv]
// Shared types and codes for the stable time-ordered event queue.
`default_nettype none

package stoeq_pkg;

  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  // Item selector carried on in_tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // place the new event, shift later entries toward the tail
    logic pop;  // shift every entry toward the head
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/stoeq_cell.sv]
// One slot of the sorted chain: holds an event and moves it to a neighbor.
`default_nettype none

module stoeq_cell
  import stoeq_pkg::*;
#(
  parameter int TIME_BITS = 32,
  parameter int PROC_BITS = 8
) (
  input  wire logic                 clk,
  input  wire cell_ctl_t            ctl,
  input  wire logic                 occ,        // slot holds an event
  input  wire logic [TIME_BITS-1:0] new_time,
  input  wire logic [PROC_BITS-1:0] new_proc,
  input  wire logic [TIME_BITS-1:0] new_created,
  input  wire logic [KIND_BITS-1:0] new_kind,
  input  wire logic                 left_flag,  // neighbor toward head yields
  input  wire logic [TIME_BITS-1:0] left_time,
  input  wire logic [PROC_BITS-1:0] left_proc,
  input  wire logic [TIME_BITS-1:0] left_created,
  input  wire logic [KIND_BITS-1:0] left_kind,
  input  wire logic [TIME_BITS-1:0] right_time,
  input  wire logic [PROC_BITS-1:0] right_proc,
  input  wire logic [TIME_BITS-1:0] right_created,
  input  wire logic [KIND_BITS-1:0] right_kind,
  output logic                      flag,       // new event belongs here or earlier
  output logic [TIME_BITS-1:0]      time_q,
  output logic [PROC_BITS-1:0]      proc_q,
  output logic [TIME_BITS-1:0]      created_q,
  output logic [KIND_BITS-1:0]      kind_q
);

  logic [TIME_BITS-1:0] time_r;
  logic [PROC_BITS-1:0] proc_r;
  logic [TIME_BITS-1:0] created_r;
  logic [KIND_BITS-1:0] kind_r;

  // Strict compare keeps equal times in arrival order; empty slots act as +inf.
  assign flag = !occ || (new_time < time_r);

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      time_r    <= right_time;
      proc_r    <= right_proc;
      created_r <= right_created;
      kind_r    <= right_kind;
    end else if (ctl.ins) begin
      if (left_flag) begin
        time_r    <= left_time;
        proc_r    <= left_proc;
        created_r <= left_created;
        kind_r    <= left_kind;
      end else if (flag) begin
        time_r    <= new_time;
        proc_r    <= new_proc;
        created_r <= new_created;
        kind_r    <= new_kind;
      end
    end
  end

  assign time_q    = time_r;
  assign proc_q    = proc_r;
  assign created_q = created_r;
  assign kind_q    = kind_r;

endmodule

`default_nettype wire

[rtl/stable_time_ordered_event_queue.sv]
// Top level of the stable time-ordered event queue: cell chain and result register.
//
//  channel | dir | handshake            | contents
//  --------+-----+----------------------+---------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: mode; tdata: time, proc, created, kind
//  out_    | out | out_tvalid/out_tready| tuser: status, valid; tdata: event + fill
//
//  All cells compare the new time in parallel and shift in the same edge, so an
//  insert or a pop can follow in the next cycle.
//  The result register holds one result; a new input transfer is taken while it
//  drains, and input stalls only while a result waits with out_tready low.
//  Reset (rst_n low, synchronous) empties the queue and drops any pending result.
//  Slot contents are not cleared; the count alone marks which slots are live.
`default_nettype none
`include "stable_time_ordered_event_queue_macros.svh"

module stable_time_ordered_event_queue
  import stoeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 32,
  parameter int PROC_BITS   = 8,
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_FIELDS  = 2 * TIME_BITS + PROC_BITS + KIND_BITS,
  localparam int IN_W       = ((IN_FIELDS + 7) / 8) * 8,
  localparam int OUT_FIELDS = 2 * TIME_BITS + PROC_BITS + KIND_BITS + CNT_BITS,
  localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // event_time, proc_id, created_time, kind
  input  wire logic             in_tuser,   // mode
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // out_time, out_proc, out_created, out_kind,
                                            // fill_count
  output logic [2:0]            out_tuser   // status[1:0], out_valid
);

  // Unpack the input transfer
  logic [TIME_BITS-1:0] in_time;
  logic [PROC_BITS-1:0] in_proc;
  logic [TIME_BITS-1:0] in_created;
  logic [KIND_BITS-1:0] in_kind;

  assign in_time    = in_tdata[TIME_BITS-1:0];
  assign in_proc    = in_tdata[TIME_BITS +: PROC_BITS];
  assign in_created = in_tdata[TIME_BITS+PROC_BITS +: TIME_BITS];
  assign in_kind    = in_tdata[2*TIME_BITS+PROC_BITS +: KIND_BITS];

  logic in_xfer;
  logic full;
  logic empty;
  logic is_insert;
  logic is_pop;

  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;

  assign in_xfer   = in_tvalid && in_tready;
  assign full      = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign is_insert = (in_tuser == MODE_INSERT);
  assign is_pop    = (in_tuser == MODE_POP);

  cell_ctl_t ctl;
  assign ctl.ins = in_xfer && is_insert && !full;
  assign ctl.pop = in_xfer && is_pop && !empty;

  // Count follows the shifts in the chain
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cell chain: index 0 is the head (earliest event)
  logic                 flag_w    [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] time_w    [QUEUE_DEPTH];
  logic [PROC_BITS-1:0] proc_w    [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] created_w [QUEUE_DEPTH];
  logic [KIND_BITS-1:0] kind_w    [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 occ;
    logic                 l_flag;
    logic [TIME_BITS-1:0] l_time;
    logic [PROC_BITS-1:0] l_proc;
    logic [TIME_BITS-1:0] l_created;
    logic [KIND_BITS-1:0] l_kind;
    logic [TIME_BITS-1:0] r_time;
    logic [PROC_BITS-1:0] r_proc;
    logic [TIME_BITS-1:0] r_created;
    logic [KIND_BITS-1:0] r_kind;

    assign occ = (CNT_BITS'(i) < count_r);

    if (i == 0) begin : g_head
      // Nothing sits ahead of the head cell
      assign l_flag    = 1'b0;
      assign l_time    = '0;
      assign l_proc    = '0;
      assign l_created = '0;
      assign l_kind    = '0;
    end else begin : g_mid
      assign l_flag    = flag_w[i-1];
      assign l_time    = time_w[i-1];
      assign l_proc    = proc_w[i-1];
      assign l_created = created_w[i-1];
      assign l_kind    = kind_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // Tail slot goes empty on a pop; its contents no longer matter
      assign r_time    = '0;
      assign r_proc    = '0;
      assign r_created = '0;
      assign r_kind    = '0;
    end else begin : g_body
      assign r_time    = time_w[i+1];
      assign r_proc    = proc_w[i+1];
      assign r_created = created_w[i+1];
      assign r_kind    = kind_w[i+1];
    end

    stoeq_cell #(
      .TIME_BITS (TIME_BITS),
      .PROC_BITS (PROC_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occ           (occ),
      .new_time      (in_time),
      .new_proc      (in_proc),
      .new_created   (in_created),
      .new_kind      (in_kind),
      .left_flag     (l_flag),
      .left_time     (l_time),
      .left_proc     (l_proc),
      .left_created  (l_created),
      .left_kind     (l_kind),
      .right_time    (r_time),
      .right_proc    (r_proc),
      .right_created (r_created),
      .right_kind    (r_kind),
      .flag          (flag_w[i]),
      .time_q        (time_w[i]),
      .proc_q        (proc_w[i]),
      .created_q     (created_w[i]),
      .kind_q        (kind_w[i])
    );
  end

  // Result register: one entry, refilled on every input transfer
  logic                 out_vld_r;
  status_t              status_r;
  logic                 evt_vld_r;
  logic [TIME_BITS-1:0] res_time_r;
  logic [PROC_BITS-1:0] res_proc_r;
  logic [TIME_BITS-1:0] res_created_r;
  logic [KIND_BITS-1:0] res_kind_r;
  logic [CNT_BITS-1:0]  res_fill_r;

  status_t status_nxt;

  always_comb begin
    priority if (is_insert && full) begin
      status_nxt = STAT_FULL;
    end else if (is_pop && empty) begin
      status_nxt = STAT_EMPTY;
    end else begin
      status_nxt = STAT_OK;
    end
  end

  assign in_tready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_xfer) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Payload: a pop on a non-empty queue shows the old head, every other transfer reports zero event fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r   <= status_nxt;
      evt_vld_r  <= ctl.pop;
      res_fill_r <= count_nxt;
      if (ctl.pop) begin
        res_time_r    <= time_w[0];
        res_proc_r    <= proc_w[0];
        res_created_r <= created_w[0];
        res_kind_r    <= kind_w[0];
      end else begin
        res_time_r    <= '0;
        res_proc_r    <= '0;
        res_created_r <= '0;
        res_kind_r    <= '0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {evt_vld_r, status_r};
  assign out_tdata  = OUT_W'({res_fill_r, res_kind_r, res_created_r, res_proc_r, res_time_r});

  // Checks
  `STOEQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_BITS'(QUEUE_DEPTH), "count over depth")
  `STOEQ_ASSERT_NEXT(a_ins_grows, ctl.ins, count_r == $past(count_r) + 1'b1, "insert lost")
  `STOEQ_ASSERT_NEXT(a_pop_result, ctl.pop, out_tvalid && evt_vld_r && status_r == STAT_OK, "pop result missing")
  `STOEQ_ASSERT_IMPL(a_evt_ok, out_tvalid && evt_vld_r, status_r == STAT_OK, "event with error status")
  `STOEQ_ASSERT_IMPL(a_no_both, 1'b1, !(ctl.ins && ctl.pop), "insert and pop together")

endmodule

`default_nettype wire

[tb/stoeq_checker.sv]
// Scoreboard for the event queue: predicts each result and compares it field by field.
module stoeq_checker
  import stoeq_pkg::*;
#(
  parameter int EV_W  = 80,
  parameter int RES_W = 88,
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [EV_W-1:0]  in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [RES_W-1:0] out_tdata,
  input  logic [2:0]       out_tuser,
  output int               mismatch_total,
  output int               results_due
);

  typedef struct packed {
    status_t     status;
    logic        valid;
    logic [31:0] ev_stamp;
    logic [7:0]  proc;
    logic [31:0] created;
    logic [2:0]  kind;
    logic [6:0]  fill;
  } queue_result_t;

  logic [31:0] held_stamp   [DEPTH];
  logic [7:0]  held_proc    [DEPTH];
  logic [31:0] held_created [DEPTH];
  logic [2:0]  held_kind    [DEPTH];
  int          held_events;

  queue_result_t pending_results[$];

  initial begin
    mismatch_total = 0;
    results_due    = 0;
    held_events    = 0;
  end

  // Apply one item to the sorted store and return what the queue must answer.
  task automatic predict_queue_result(input logic mode, input logic [EV_W-1:0] d,
                                      output queue_result_t r);
    int          pos;
    bit          found;
    logic [31:0] stamp;
    r        = '0;
    r.status = STAT_OK;
    stamp    = d[31:0];
    if (mode == MODE_INSERT) begin
      if (held_events >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        pos   = held_events;
        found = 0;
        for (int i = 0; i < held_events; i++) begin
          if (!found && stamp < held_stamp[i]) begin
            pos   = i;
            found = 1;
          end
        end
        for (int i = held_events; i > pos; i--) begin
          held_stamp[i]   = held_stamp[i-1];
          held_proc[i]    = held_proc[i-1];
          held_created[i] = held_created[i-1];
          held_kind[i]    = held_kind[i-1];
        end
        held_stamp[pos]   = stamp;
        held_proc[pos]    = d[39:32];
        held_created[pos] = d[71:40];
        held_kind[pos]    = d[74:72];
        held_events++;
      end
    end else if (held_events == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.valid    = 1'b1;
      r.ev_stamp = held_stamp[0];
      r.proc     = held_proc[0];
      r.created  = held_created[0];
      r.kind     = held_kind[0];
      for (int i = 1; i < held_events; i++) begin
        held_stamp[i-1]   = held_stamp[i];
        held_proc[i-1]    = held_proc[i];
        held_created[i-1] = held_created[i];
        held_kind[i-1]    = held_kind[i];
      end
      held_events--;
    end
    r.fill = held_events[6:0];
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t next_due;
    if (rst_n) begin
      // compare first: a result leaving now never belongs to an item entering now
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected result, expected none, actual %0h/%0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("status",      32'(want.status),   32'(out_tuser[1:0]));
          check_field("out_valid",   32'(want.valid),    32'(out_tuser[2]));
          check_field("out_time",    want.ev_stamp,      out_tdata[31:0]);
          check_field("out_proc",    32'(want.proc),     32'(out_tdata[39:32]));
          check_field("out_created", want.created,       out_tdata[71:40]);
          check_field("out_kind",    32'(want.kind),     32'(out_tdata[74:72]));
          check_field("fill_count",  32'(want.fill),     32'(out_tdata[81:75]));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_queue_result(in_tuser, in_tdata, next_due);
        pending_results.insert(pending_results.size(), next_due);
      end
      results_due = pending_results.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the event queue: clock, reset, stimulus, back-pressure and verdict.
module tb
  import stoeq_pkg::*;
();

  localparam int EV_W   = 80;   // time, proc, created, kind packed from bit 0
  localparam int RES_W  = 88;   // time, proc, created, kind, fill packed from bit 0
  localparam int DEPTH  = 64;
  localparam int ITEMS  = 900;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [EV_W-1:0]  in_tdata;     // event_time, proc_id, created_time, kind
  logic             in_tuser;     // mode
  logic             out_tvalid;
  logic             out_tready;
  logic [RES_W-1:0] out_tdata;    // out_time, out_proc, out_created, out_kind, fill_count
  logic [2:0]       out_tuser;    // status[1:0], out_valid

  int mismatch_total;
  int results_due;

  // Idle controls: percent chance that the source pauses before an item and
  // that the sink starts a stall. Phases change them, zero gives clean bursts.
  int src_gap_pct;
  int sink_stall_pct;
  int stall_left;

  // Running fill level as seen from the stimulus side, used only to steer
  // phases toward full and empty.
  int fill_guess;
  int sent_items;

  stable_time_ordered_event_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stoeq_checker #(.EV_W(EV_W), .RES_W(RES_W), .DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_total (mismatch_total),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Timestamps: small values give many ties, the ends of the range hit the
  // unsigned compare limits, full random toggles every bit.
  function automatic logic [31:0] choose_stamp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 7);
    if (r == 4) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [EV_W-1:0] pack_event(input logic [31:0] stamp,
                                                 input logic [7:0] proc,
                                                 input logic [31:0] created,
                                                 input logic [2:0] kind);
    return {5'b0, kind, created, proc, stamp};
  endfunction

  // Sink side: hold out_tready low for random stalls, otherwise take results.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Present one item and hold it until the transfer happens. Valid stays high
  // between back-to-back items and drops only for a pause.
  task automatic put_item(input logic mode, input logic [EV_W-1:0] d);
    int gap;
    gap = ($urandom_range(0, 99) < src_gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (mode == MODE_INSERT) begin
      if (fill_guess < DEPTH) fill_guess++;
    end else if (fill_guess > 0) begin
      fill_guess--;
    end
  endtask

  task automatic put_insert(input logic [31:0] stamp);
    put_item(MODE_INSERT, pack_event(stamp, 8'($urandom), $urandom,
                                     3'($urandom_range(0, 7))));
  endtask

  task automatic put_pop();
    // payload of a pop is ignored, randomize it anyway
    put_item(MODE_POP, pack_event($urandom, 8'($urandom), $urandom,
                                  3'($urandom_range(0, 7))));
  endtask

  // Pick the idle profile for the next phase, sometimes none at all.
  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      1: begin
        src_gap_pct    = 0;
        sink_stall_pct = $urandom_range(20, 60);
      end
      2: begin
        src_gap_pct    = $urandom_range(20, 60);
        sink_stall_pct = 0;
      end
      default: begin
        src_gap_pct    = $urandom_range(5, 40);
        sink_stall_pct = $urandom_range(5, 40);
      end
    endcase
  endtask

  initial begin
    int phase_len;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = MODE_INSERT;
    out_tready     = 1'b0;
    stall_left     = 0;
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    fill_guess     = 0;
    sent_items     = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop on an empty queue first.
    put_pop();
    // Field extremes, including both extreme kinds.
    put_item(MODE_INSERT, pack_event(32'h0, 8'h00, 32'h0, 3'd0));
    put_item(MODE_INSERT, pack_event(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 3'd7));
    // Equal timestamps must leave in arrival order.
    put_item(MODE_INSERT, pack_event(32'd100, 8'd1, 32'h1111_1111, 3'd6));
    put_item(MODE_INSERT, pack_event(32'd100, 8'd2, 32'h2222_2222, 3'd1));
    put_item(MODE_INSERT, pack_event(32'd100, 8'd3, 32'h3333_3333, 3'd2));
    put_item(MODE_INSERT, pack_event(32'd50, 8'd4, 32'h4444_4444, 3'd3));
    // Ties at both ends of the time range.
    put_item(MODE_INSERT, pack_event(32'hFFFF_FFFF, 8'd5, 32'h5555_5555, 3'd4));
    put_item(MODE_INSERT, pack_event(32'h0, 8'd6, 32'hAAAA_AAAA, 3'd5));
    // Drain everything, then pop on empty once more.
    repeat (9) put_pop();

    // Random phases: fill past full and drain past empty, or mixed traffic
    // with stamps from choose_stamp so ordering and ties get exercised.
    while (sent_items < ITEMS) begin
      pick_idling();
      if ($urandom_range(0, 2) == 0) begin
        while (fill_guess < DEPTH) put_insert(choose_stamp());
        repeat ($urandom_range(1, 3)) put_insert(choose_stamp());   // dropped, full
        while (fill_guess > 0) put_pop();
        repeat ($urandom_range(1, 2)) put_pop();                    // empty
      end else begin
        phase_len = $urandom_range(30, 80);
        repeat (phase_len) begin
          if ($urandom_range(0, 99) < 55) put_insert(choose_stamp());
          else put_pop();
        end
      end
    end
    in_tvalid <= 1'b0;

    // Let every expected result arrive, then keep watching for strays.
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_total == 0 && results_due == 0) begin
      $display("stable_time_ordered_event_queue test passed");
    end else begin
      $display("stable_time_ordered_event_queue test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("stable_time_ordered_event_queue test failed");
    $finish;
  end

endmodule
